[design/gsdc_pkg.sv]
// Package for the gesture stroke direction coder.
// Holds widths, codes, reset values and the token type; depends on nothing.
package gsdc_pkg;

    localparam int MAX_POINTS  = 64;
    localparam int KEPT_W      = $clog2(MAX_POINTS + 1);

    localparam int COORD_W     = 16;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int STEP_W      = 10;
    localparam int STEP_SQ_W   = 2 * STEP_W;
    localparam int OP_W        = 2;
    localparam int KIND_W      = 2;
    localparam int CODE_W      = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = STEP_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // event codes
    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_MOVE  = 2'd1;
    localparam logic [OP_W-1:0] OP_END   = 2'd2;

    // token kinds
    localparam logic [KIND_W-1:0] KIND_BUTTON    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DIRECTION = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END       = 2'd2;

    // direction codes, clockwise from up
    localparam logic [CODE_W-1:0] DIR_UP         = 4'd0;
    localparam logic [CODE_W-1:0] DIR_UP_RIGHT   = 4'd1;
    localparam logic [CODE_W-1:0] DIR_RIGHT      = 4'd2;
    localparam logic [CODE_W-1:0] DIR_DOWN_RIGHT = 4'd3;
    localparam logic [CODE_W-1:0] DIR_DOWN       = 4'd4;
    localparam logic [CODE_W-1:0] DIR_DOWN_LEFT  = 4'd5;
    localparam logic [CODE_W-1:0] DIR_LEFT       = 4'd6;
    localparam logic [CODE_W-1:0] DIR_UP_LEFT    = 4'd7;
    localparam logic [CODE_W-1:0] DIR_NONE       = 4'd8;
    localparam logic [CODE_W-1:0] CODE_ZERO      = 4'd0;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEP  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EIGHT_WAY = 1'b1;

    localparam logic [STEP_W-1:0]    MIN_STEP_RESET  = 10'd16;
    localparam logic [STEP_SQ_W-1:0] MIN_SQ_RESET    = STEP_SQ_W'(16 * 16);
    localparam logic                 EIGHT_WAY_RESET = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CODE_W-1:0] code;
        logic              last;
    } t_token;

endpackage

[design/gesture_stroke_direction_coder_top.sv]
// Top level of the gesture stroke direction coder: point filter, sector
// finder, token builder and result queue in one module. Uses gsdc_pkg.
//
//  channel   direction  handshake                    payload
//  ------------------------------------------------------------------------
//  events    in         i_in_valid / o_in_stall      i_op, i_pos_x, i_pos_y,
//                                                    i_button_code
//  tokens    out        o_out_valid / i_out_stall    o_token_kind,
//                                                    o_token_code, o_last
//  config    in         i_cfg_we (no wait)           i_cfg_index, i_cfg_data
//
// One request is taken per cycle while o_in_stall is low. A token passes the
// input register, filter stage, product stage and queue before it can itself
// be taken.
// Each request yields up to two tokens, so the token channel bounds the rate
// when many requests give two. A four-entry queue decouples the sides; the
// pipeline holds, and o_in_stall rises, while fewer than two entries are
// free. Reset (synchronous, active low) clears the stage valids, the open
// gesture, the queue, and sets the margin to 16 and eight-way mode.
module gesture_stroke_direction_coder_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [gsdc_pkg::OP_W-1:0]             i_op,
    input  logic signed [gsdc_pkg::COORD_W-1:0]   i_pos_x,
    input  logic signed [gsdc_pkg::COORD_W-1:0]   i_pos_y,
    input  logic [gsdc_pkg::CODE_W-1:0]           i_button_code,

    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [gsdc_pkg::KIND_W-1:0]           o_token_kind,
    output logic [gsdc_pkg::CODE_W-1:0]           o_token_code,
    output logic                                  o_last,

    input  logic                                  i_cfg_we,
    input  logic [gsdc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [gsdc_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int CW = gsdc_pkg::COORD_W;
    localparam int DW = gsdc_pkg::DIFF_W;
    localparam int SW = gsdc_pkg::STEP_W;
    localparam int KW = gsdc_pkg::KEPT_W;
    localparam int SUM_W = CW + 1;

    // ------------------------------------------------------------------
    // Configuration registers. The squared margin is kept alongside the
    // margin so the filter never multiplies by it.
    // ------------------------------------------------------------------
    logic [SW-1:0]                  r_min_step;
    logic [gsdc_pkg::STEP_SQ_W-1:0] r_min_sq;
    logic                           r_eight_way;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_step  <= gsdc_pkg::MIN_STEP_RESET;
            r_min_sq    <= gsdc_pkg::MIN_SQ_RESET;
            r_eight_way <= gsdc_pkg::EIGHT_WAY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gsdc_pkg::CFG_MIN_STEP: begin
                    r_min_step <= i_cfg_data;
                    r_min_sq   <= gsdc_pkg::STEP_SQ_W'(i_cfg_data) *
                                  gsdc_pkg::STEP_SQ_W'(i_cfg_data);
                end
                gsdc_pkg::CFG_EIGHT_WAY: begin
                    r_eight_way <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance: every stage moves together whenever the queue can
    // take the two tokens that the last stage may produce.
    // ------------------------------------------------------------------
    logic [gsdc_pkg::QCNT_W-1:0] r_cnt;
    logic                        w_adv;
    logic                        w_in_take;

    assign w_adv      = (r_cnt <= gsdc_pkg::QCNT_W'(gsdc_pkg::QUEUE_DEPTH - 2));
    assign o_in_stall = !w_adv;
    assign w_in_take  = i_in_valid && w_adv;

    // ------------------------------------------------------------------
    // Stage A: input register.
    // ------------------------------------------------------------------
    logic                          r_a_valid;
    logic [gsdc_pkg::OP_W-1:0]     r_a_op;
    logic signed [CW-1:0]          r_a_x;
    logic signed [CW-1:0]          r_a_y;
    logic [gsdc_pkg::CODE_W-1:0]   r_a_button;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= w_in_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_a_op     <= i_op;
            r_a_x      <= i_pos_x;
            r_a_y      <= i_pos_y;
            r_a_button <= i_button_code;
        end
    end

    // ------------------------------------------------------------------
    // Stage A logic: gesture state and the distance filter. The last kept
    // point feeds straight back, so the keep decision never waits on it:
    // a point with either offset at or beyond the margin is kept at once,
    // otherwise both offsets are below 1024 and narrow squares suffice.
    // ------------------------------------------------------------------
    logic                 r_active;
    logic [KW-1:0]        r_kept;
    logic signed [CW-1:0] r_prev_x;
    logic signed [CW-1:0] r_prev_y;

    logic [DW-1:0]        w_dx;
    logic [DW-1:0]        w_dy;
    logic [DW-1:0]        w_dx_neg;
    logic [DW-1:0]        w_dy_neg;
    logic [CW-1:0]        w_ax;
    logic [CW-1:0]        w_ay;
    logic                 w_near_x;
    logic                 w_near_y;
    logic [gsdc_pkg::STEP_SQ_W-1:0] w_sq_x;
    logic [gsdc_pkg::STEP_SQ_W-1:0] w_sq_y;
    logic [gsdc_pkg::STEP_SQ_W:0]   w_d2;
    logic                 w_far;
    logic                 w_a_start;
    logic                 w_a_offer;
    logic                 w_a_end;
    logic                 w_a_keep;

    always_comb begin
        w_dx     = DW'(r_a_x) - DW'(r_prev_x);
        w_dy     = DW'(r_a_y) - DW'(r_prev_y);
        w_dx_neg = DW'(0) - w_dx;
        w_dy_neg = DW'(0) - w_dy;
        w_ax     = w_dx[DW-1] ? w_dx_neg[CW-1:0] : w_dx[CW-1:0];
        w_ay     = w_dy[DW-1] ? w_dy_neg[CW-1:0] : w_dy[CW-1:0];
        w_near_x = (w_ax < CW'(r_min_step));
        w_near_y = (w_ay < CW'(r_min_step));
        w_sq_x   = gsdc_pkg::STEP_SQ_W'(w_ax[SW-1:0]) *
                   gsdc_pkg::STEP_SQ_W'(w_ax[SW-1:0]);
        w_sq_y   = gsdc_pkg::STEP_SQ_W'(w_ay[SW-1:0]) *
                   gsdc_pkg::STEP_SQ_W'(w_ay[SW-1:0]);
        w_d2     = {1'b0, w_sq_x} + {1'b0, w_sq_y};
        w_far    = !w_near_x || !w_near_y || (w_d2 >= {1'b0, r_min_sq});

        w_a_start = r_a_valid && (r_a_op == gsdc_pkg::OP_START);
        w_a_offer = r_a_valid && r_active &&
                    ((r_a_op == gsdc_pkg::OP_MOVE) || (r_a_op == gsdc_pkg::OP_END));
        w_a_end   = w_a_offer && (r_a_op == gsdc_pkg::OP_END);
        w_a_keep  = w_a_offer && (r_kept < KW'(gsdc_pkg::MAX_POINTS)) && w_far;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_kept   <= '0;
            r_prev_x <= '0;
            r_prev_y <= '0;
        end else if (w_adv) begin
            if (w_a_start) begin
                // open anew, dropping any gesture still open
                r_active <= 1'b1;
                r_kept   <= KW'(1);
                r_prev_x <= r_a_x;
                r_prev_y <= r_a_y;
            end else begin
                if (w_a_keep) begin
                    r_kept   <= r_kept + KW'(1);
                    r_prev_x <= r_a_x;
                    r_prev_y <= r_a_y;
                end
                if (w_a_end) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage B: offsets of an offered point; form the squares for the sector
    // test. Idle and unused events leave a bubble.
    // ------------------------------------------------------------------
    logic                        r_b_valid;
    logic                        r_b_start;
    logic                        r_b_keep;
    logic                        r_b_end;
    logic [gsdc_pkg::CODE_W-1:0] r_b_button;
    logic [CW-1:0]               r_b_ax;
    logic [CW-1:0]               r_b_ay;
    logic                        r_b_dxn;
    logic                        r_b_dyn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_adv) begin
            r_b_valid <= w_a_start || w_a_offer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_start  <= w_a_start;
            r_b_keep   <= w_a_keep;
            r_b_end    <= w_a_end;
            r_b_button <= r_a_button;
            r_b_ax     <= w_ax;
            r_b_ay     <= w_ay;
            r_b_dxn    <= w_dx[DW-1];
            r_b_dyn    <= w_dy[DW-1];
        end
    end

    logic [SUM_W-1:0]   w_sum;
    logic [2*SUM_W-1:0] w_s;
    logic [2*CW-1:0]    w_aa;
    logic [2*CW-1:0]    w_bb;

    always_comb begin
        w_sum = SUM_W'(r_b_ax) + SUM_W'(r_b_ay);
        w_s   = (2*SUM_W)'(w_sum) * (2*SUM_W)'(w_sum);
        w_aa  = (2*CW)'(r_b_ax) * (2*CW)'(r_b_ax);
        w_bb  = (2*CW)'(r_b_ay) * (2*CW)'(r_b_ay);
    end

    // ------------------------------------------------------------------
    // Stage C: pick the sector, decide on a direction token, build tokens.
    // ------------------------------------------------------------------
    logic                        r_c_valid;
    logic                        r_c_start;
    logic                        r_c_keep;
    logic                        r_c_end;
    logic [gsdc_pkg::CODE_W-1:0] r_c_button;
    logic [2*SUM_W-1:0]          r_c_s;
    logic [2*CW-1:0]             r_c_aa;
    logic [2*CW-1:0]             r_c_bb;
    logic                        r_c_a_zero;
    logic                        r_c_b_zero;
    logic                        r_c_a_gt_b;
    logic                        r_c_b_gt_a;
    logic                        r_c_dxn;
    logic                        r_c_dyn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_adv) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c_start  <= r_b_start;
            r_c_keep   <= r_b_keep;
            r_c_end    <= r_b_end;
            r_c_button <= r_b_button;
            r_c_s      <= w_s;
            r_c_aa     <= w_aa;
            r_c_bb     <= w_bb;
            r_c_a_zero <= (r_b_ax == '0);
            r_c_b_zero <= (r_b_ay == '0);
            r_c_a_gt_b <= (r_b_ax > r_b_ay);
            r_c_b_gt_a <= (r_b_ay > r_b_ax);
            r_c_dxn    <= r_b_dxn;
            r_c_dyn    <= r_b_dyn;
        end
    end

    logic [gsdc_pkg::CODE_W-1:0] r_prev_dir;
    logic [gsdc_pkg::CODE_W-1:0] r_last_dir;
    logic [gsdc_pkg::CODE_W-1:0] w_dir;
    logic                        w_dx_pos;
    logic                        w_dy_pos;
    logic                        w_emit;
    logic [2*SUM_W-1:0]          w_two_aa;
    logic [2*SUM_W-1:0]          w_two_bb;

    always_comb begin
        w_dx_pos = !r_c_dxn && !r_c_a_zero;
        w_dy_pos = !r_c_dyn && !r_c_b_zero;
        w_two_aa = {(2*SUM_W-2*CW-1)'(0), r_c_aa, 1'b0};
        w_two_bb = {(2*SUM_W-2*CW-1)'(0), r_c_bb, 1'b0};

        if (r_c_a_zero) begin
            // straight up or down; no move at all counts as up
            w_dir = w_dy_pos ? gsdc_pkg::DIR_DOWN : gsdc_pkg::DIR_UP;
        end else if (r_eight_way) begin
            // (a+b)^2 < 2b^2 is |dx|/|dy| below tan 22.5, exactly
            if (r_c_s < w_two_bb) begin
                w_dir = r_c_dyn ? gsdc_pkg::DIR_UP : gsdc_pkg::DIR_DOWN;
            end else if (r_c_s < w_two_aa) begin
                w_dir = w_dx_pos ? gsdc_pkg::DIR_RIGHT : gsdc_pkg::DIR_LEFT;
            end else if (w_dx_pos) begin
                w_dir = r_c_dyn ? gsdc_pkg::DIR_UP_RIGHT : gsdc_pkg::DIR_DOWN_RIGHT;
            end else begin
                w_dir = w_dy_pos ? gsdc_pkg::DIR_DOWN_LEFT : gsdc_pkg::DIR_UP_LEFT;
            end
        end else begin
            if (r_c_b_gt_a) begin
                w_dir = r_c_dyn ? gsdc_pkg::DIR_UP : gsdc_pkg::DIR_DOWN;
            end else if (r_c_a_gt_b) begin
                w_dir = w_dx_pos ? gsdc_pkg::DIR_RIGHT : gsdc_pkg::DIR_LEFT;
            end else if (w_dx_pos) begin
                // exact diagonal: take the sector clockwise of it
                w_dir = r_c_dyn ? gsdc_pkg::DIR_RIGHT : gsdc_pkg::DIR_DOWN;
            end else begin
                w_dir = w_dy_pos ? gsdc_pkg::DIR_LEFT : gsdc_pkg::DIR_UP;
            end
        end

        w_emit = r_c_keep && (w_dir == r_prev_dir) && (w_dir != r_last_dir);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_dir <= gsdc_pkg::DIR_NONE;
            r_last_dir <= gsdc_pkg::DIR_NONE;
        end else if (w_adv && r_c_valid) begin
            if (r_c_start) begin
                r_prev_dir <= gsdc_pkg::DIR_NONE;
                r_last_dir <= gsdc_pkg::DIR_NONE;
            end else if (r_c_keep) begin
                r_prev_dir <= w_dir;
                if (w_emit) begin
                    r_last_dir <= w_dir;
                end
            end
        end
    end

    // tokens of this request, in order
    gsdc_pkg::t_token w_tok0;
    gsdc_pkg::t_token w_tok1;
    logic [1:0]       w_tok_n;
    gsdc_pkg::t_token w_end_tok;

    always_comb begin
        w_end_tok = '{kind: gsdc_pkg::KIND_END, code: gsdc_pkg::CODE_ZERO, last: 1'b1};
        w_tok0    = w_end_tok;
        w_tok1    = w_end_tok;
        w_tok_n   = 2'd0;
        if (r_c_valid) begin
            if (r_c_start) begin
                w_tok0  = '{kind: gsdc_pkg::KIND_BUTTON, code: r_c_button, last: 1'b1};
                w_tok_n = 2'd1;
            end else if (w_emit) begin
                w_tok0  = '{kind: gsdc_pkg::KIND_DIRECTION, code: w_dir, last: !r_c_end};
                w_tok_n = r_c_end ? 2'd2 : 2'd1;
            end else if (r_c_end) begin
                w_tok_n = 2'd1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result queue: up to two tokens in a cycle, one out unless stalled.
    // ------------------------------------------------------------------
    gsdc_pkg::t_token              r_q [gsdc_pkg::QUEUE_DEPTH];
    logic [gsdc_pkg::QPTR_W-1:0]   r_wp;
    logic [gsdc_pkg::QPTR_W-1:0]   r_rp;
    logic [gsdc_pkg::QPTR_W-1:0]   w_wp1;
    logic [1:0]                    w_push_n;
    logic                          w_pop;

    assign w_push_n    = w_adv ? w_tok_n : 2'd0;
    assign o_out_valid = (r_cnt != '0);
    assign w_pop       = o_out_valid && !i_out_stall;
    assign w_wp1       = r_wp + gsdc_pkg::QPTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + gsdc_pkg::QPTR_W'(w_push_n);
            if (w_pop) begin
                r_rp <= r_rp + gsdc_pkg::QPTR_W'(1);
            end
            r_cnt <= r_cnt + gsdc_pkg::QCNT_W'(w_push_n) -
                     gsdc_pkg::QCNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_n != 2'd0) begin
            r_q[r_wp] <= w_tok0;
        end
        if (w_push_n == 2'd2) begin
            r_q[w_wp1] <= w_tok1;
        end
    end

    assign o_token_kind = r_q[r_rp].kind;
    assign o_token_code = r_q[r_rp].code;
    assign o_last       = r_q[r_rp].last;

endmodule

[sim/gesture_stroke_direction_coder_top_tb.sv]
// Self-checking testbench for gesture_stroke_direction_coder_top.
// Holds its own stroke predictor, stimulus and token checker; depends on gsdc_pkg and the block.
module gesture_stroke_direction_coder_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OPW = gsdc_pkg::OP_W;
    localparam int CW  = gsdc_pkg::COORD_W;
    localparam int SW  = gsdc_pkg::STEP_W;
    localparam int KNW = gsdc_pkg::KIND_W;
    localparam int CDW = gsdc_pkg::CODE_W;
    localparam int IXW = gsdc_pkg::CFG_IDX_W;
    localparam int DTW = gsdc_pkg::CFG_DATA_W;

    // op 3 has no name in the package; the block must ignore it
    localparam logic [OPW-1:0] OP_UNUSED = 2'd3;

    localparam int SETTLE_CYCLES = 12;     // pipeline is four deep, allow plenty more
    localparam int CYCLE_LIMIT   = 100000;
    localparam int REPORT_MAX    = 10;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    logic                         i_clk;
    logic                         i_rst_n       = 1'b0;
    logic                         i_in_valid    = 1'b0;
    logic                         o_in_stall;
    logic [OPW-1:0]               i_op          = gsdc_pkg::OP_START;
    logic signed [CW-1:0]         i_pos_x       = '0;
    logic signed [CW-1:0]         i_pos_y       = '0;
    logic [CDW-1:0]               i_button_code = '0;
    logic                         o_out_valid;
    logic                         i_out_stall   = 1'b0;
    logic [KNW-1:0]               o_token_kind;
    logic [CDW-1:0]               o_token_code;
    logic                         o_last;
    logic                         i_cfg_we      = 1'b0;
    logic [IXW-1:0]               i_cfg_index   = gsdc_pkg::CFG_MIN_STEP;
    logic [DTW-1:0]               i_cfg_data    = '0;

    gesture_stroke_direction_coder_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_button_code (i_button_code),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_token_kind  (o_token_kind),
        .o_token_code  (o_token_code),
        .o_last        (o_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Stroke predictor state: a private copy of the registers and of the
    // open gesture, advanced once per request taken by the block.
    // ------------------------------------------------------------------
    logic [SW-1:0]                cfg_min_step = gsdc_pkg::MIN_STEP_RESET;
    logic                         cfg_eight    = gsdc_pkg::EIGHT_WAY_RESET;
    logic                         stroke_open  = 1'b0;
    int                           kept_count   = 0;
    logic signed [CW-1:0]         anchor_x     = '0;
    logic signed [CW-1:0]         anchor_y     = '0;
    logic [CDW-1:0]               prev_dir     = gsdc_pkg::DIR_NONE;
    logic [CDW-1:0]               emitted_dir  = gsdc_pkg::DIR_NONE;

    gsdc_pkg::t_token             pending_tokens[$];

    int                           send_idle_pct   = 0;
    int                           recv_stall_pct  = 0;
    int                           requests_taken  = 0;
    int                           requests_ignored = 0;
    int                           tokens_checked  = 0;
    int                           token_mismatches = 0;
    int                           cycle_count     = 0;

    gsdc_pkg::t_token             seen_token;
    gsdc_pkg::t_token             wanted_token;

    // ------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Abandon the run if the tokens never drain; the normal end comes far sooner.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timed out after %0d cycles, %0d tokens still awaited",
                 cycle_count, pending_tokens.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic gsdc_pkg::t_token make_token(input logic [KNW-1:0] kind,
                                                    input logic [CDW-1:0] code,
                                                    input logic last);
        gsdc_pkg::t_token tok;
        tok.kind = kind;
        tok.code = code;
        tok.last = last;
        return tok;
    endfunction

    // ------------------------------------------------------------------
    // Direction sector of one step, clockwise from up, y growing downward.
    // Exact integer compares: squared sums stand in for the tangent of
    // 22.5 degrees, and four-way diagonals fall to the clockwise side.
    // ------------------------------------------------------------------
    function automatic logic [CDW-1:0] stroke_sector(input int dx, input int dy);
        longint ax;
        longint ay;
        longint sum_sq;
        ax = (dx < 0) ? -longint'(dx) : longint'(dx);
        ay = (dy < 0) ? -longint'(dy) : longint'(dy);
        // a purely vertical step, or no step at all, points up unless it goes down
        if (ax == 0)
            return (dy > 0) ? gsdc_pkg::DIR_DOWN : gsdc_pkg::DIR_UP;
        if (cfg_eight) begin
            sum_sq = (ax + ay) * (ax + ay);
            if (sum_sq < 2 * ay * ay)
                return (dy < 0) ? gsdc_pkg::DIR_UP : gsdc_pkg::DIR_DOWN;
            if (sum_sq < 2 * ax * ax)
                return (dx > 0) ? gsdc_pkg::DIR_RIGHT : gsdc_pkg::DIR_LEFT;
            if (dx > 0)
                return (dy < 0) ? gsdc_pkg::DIR_UP_RIGHT : gsdc_pkg::DIR_DOWN_RIGHT;
            return (dy > 0) ? gsdc_pkg::DIR_DOWN_LEFT : gsdc_pkg::DIR_UP_LEFT;
        end
        if (ay > ax)
            return (dy < 0) ? gsdc_pkg::DIR_UP : gsdc_pkg::DIR_DOWN;
        if (ax > ay)
            return (dx > 0) ? gsdc_pkg::DIR_RIGHT : gsdc_pkg::DIR_LEFT;
        // exact diagonal: take the clockwise neighbour
        if (dx > 0)
            return (dy < 0) ? gsdc_pkg::DIR_RIGHT : gsdc_pkg::DIR_DOWN;
        return (dy > 0) ? gsdc_pkg::DIR_LEFT : gsdc_pkg::DIR_UP;
    endfunction

    // Advance the predictor by one request and queue the tokens it causes.
    // Returns 0 when the block should ignore the request outright.
    function automatic bit predict_tokens(input logic [OPW-1:0] op,
                                          input logic signed [CW-1:0] x,
                                          input logic signed [CW-1:0] y,
                                          input logic [CDW-1:0] btn);
        int                dx;
        int                dy;
        longint            ax;
        longint            ay;
        logic [CDW-1:0]    dir;
        if (op == gsdc_pkg::OP_START) begin
            // a start always reopens, dropping any gesture still in progress
            pending_tokens.push_back(make_token(gsdc_pkg::KIND_BUTTON, btn, 1'b1));
            stroke_open = 1'b1;
            kept_count  = 1;
            anchor_x    = x;
            anchor_y    = y;
            prev_dir    = gsdc_pkg::DIR_NONE;
            emitted_dir = gsdc_pkg::DIR_NONE;
            return 1'b1;
        end
        if (op == OP_UNUSED || !stroke_open)
            return 1'b0;
        // offer the point: drop it when the gesture is full or the step is short
        if (kept_count < gsdc_pkg::MAX_POINTS) begin
            dx = int'(x) - int'(anchor_x);
            dy = int'(y) - int'(anchor_y);
            ax = (dx < 0) ? -longint'(dx) : longint'(dx);
            ay = (dy < 0) ? -longint'(dy) : longint'(dy);
            if (ax * ax + ay * ay >= longint'(cfg_min_step) * longint'(cfg_min_step)) begin
                dir = stroke_sector(dx, dy);
                if (dir == prev_dir && dir != emitted_dir) begin
                    emitted_dir = dir;
                    pending_tokens.push_back(make_token(gsdc_pkg::KIND_DIRECTION, dir,
                                                        op == gsdc_pkg::OP_MOVE));
                end
                prev_dir = dir;
                anchor_x = x;
                anchor_y = y;
                kept_count++;
            end
        end
        if (op == gsdc_pkg::OP_END) begin
            pending_tokens.push_back(make_token(gsdc_pkg::KIND_END, gsdc_pkg::CODE_ZERO,
                                                1'b1));
            stroke_open = 1'b0;
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Token side: stall at random, compare every token taken with the
    // oldest one awaited.
    // ------------------------------------------------------------------
    always @(posedge i_clk)
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);

    task automatic report_mismatch(input bit awaited);
        token_mismatches++;
        if (token_mismatches <= REPORT_MAX) begin
            if (awaited)
                $display("cycle %0d: expected kind/code/last %0d/%0d/%0d, got %0d/%0d/%0d",
                         cycle_count, wanted_token.kind, wanted_token.code,
                         wanted_token.last, seen_token.kind, seen_token.code,
                         seen_token.last);
            else
                $display("cycle %0d: expected no token, got kind/code/last %0d/%0d/%0d",
                         cycle_count, seen_token.kind, seen_token.code, seen_token.last);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen_token.kind = o_token_kind;
            seen_token.code = o_token_code;
            seen_token.last = o_last;
            tokens_checked++;
            if (pending_tokens.size() == 0) begin
                report_mismatch(1'b0);
            end else begin
                wanted_token = pending_tokens.pop_front();
                if (seen_token.kind != wanted_token.kind ||
                    seen_token.code != wanted_token.code ||
                    seen_token.last != wanted_token.last)
                    report_mismatch(1'b1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct  = 77;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct = 77;
            end
            default: begin
                send_idle_pct  = 9;
                recv_stall_pct = 9;
            end
        endcase
    endtask

    // Present one request, hold it until taken, then predict its tokens.
    // Valid stays high into the next request unless an idle gap is drawn.
    task automatic send_event(input logic [OPW-1:0] op,
                              input logic signed [CW-1:0] x,
                              input logic signed [CW-1:0] y,
                              input logic [CDW-1:0] btn);
        int gap;
        if (!i_in_valid)
            i_in_valid <= 1'b1;
        i_op          <= op;
        i_pos_x       <= x;
        i_pos_y       <= y;
        i_button_code <= btn;
        do
            @(posedge i_clk);
        while (o_in_stall);
        requests_taken++;
        if (!predict_tokens(op, x, y, btn))
            requests_ignored++;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct)
            gap = $urandom_range(1, 4);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid, wait for every awaited token, then let the pipeline settle
    // so that requests which produce nothing have left it too.
    task automatic drain_tokens();
        if (i_in_valid)
            i_in_valid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register writes happen only with the block idle.
    task automatic write_register(input logic [IXW-1:0] idx, input int value);
        drain_tokens();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= DTW'(value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == gsdc_pkg::CFG_MIN_STEP)
            cfg_min_step = SW'(value);
        else
            cfg_eight = value[0];
    endtask

    function automatic int signed_spread(input int reach);
        return int'($urandom_range(0, 2 * reach)) - reach;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset margin and eight-way mode: ignored requests, drops, emission
    // rules, end with and without a direction token, restart, extremes.
    task automatic test_directed_tokens();
        send_event(gsdc_pkg::OP_MOVE, 16'sd5, 16'sd5, 4'd3);    // no gesture open: ignore
        send_event(gsdc_pkg::OP_END, 16'sd5, 16'sd5, 4'd3);
        send_event(gsdc_pkg::OP_START, 16'sd0, 16'sd0, 4'd15);
        send_event(gsdc_pkg::OP_MOVE, 16'sd0, -16'sd20, 4'd0);  // straight up, first direction
        send_event(gsdc_pkg::OP_MOVE, 16'sd0, -16'sd40, 4'd0);  // up again: emit
        send_event(gsdc_pkg::OP_MOVE, 16'sd0, -16'sd45, 4'd0);  // under the margin: drop
        send_event(OP_UNUSED, 16'sd1, 16'sd1, 4'd9);
        send_event(gsdc_pkg::OP_MOVE, 16'sd30, -16'sd40, 4'd0); // right
        send_event(gsdc_pkg::OP_END, 16'sd60, -16'sd40, 4'd0);  // right again, then the marker
        send_event(gsdc_pkg::OP_START, -16'sd32768, -16'sd32768, 4'd0);
        send_event(gsdc_pkg::OP_MOVE, 16'sd32767, 16'sd32767, 4'd0);   // widest step there is
        send_event(gsdc_pkg::OP_START, 16'sd32767, -16'sd32768, 4'd10); // restart mid-gesture
        send_event(gsdc_pkg::OP_MOVE, -16'sd32768, 16'sd32767, 4'd0);
        send_event(gsdc_pkg::OP_MOVE, -16'sd32768, 16'sd32767, 4'd0);  // zero step: drop
        send_event(gsdc_pkg::OP_END, -16'sd32768, 16'sd32767, 4'd0);   // marker only
    endtask

    // Four sectors with no margin: zero step, and each diagonal going to
    // its clockwise neighbour.
    task automatic test_four_way_sectors();
        write_register(gsdc_pkg::CFG_MIN_STEP, 0);
        write_register(gsdc_pkg::CFG_EIGHT_WAY, 0);
        send_event(gsdc_pkg::OP_START, 16'sd100, 16'sd100, 4'd5);
        send_event(gsdc_pkg::OP_MOVE, 16'sd100, 16'sd100, 4'd0);   // zero step counts as up
        send_event(gsdc_pkg::OP_MOVE, 16'sd100, 16'sd100, 4'd0);
        send_event(gsdc_pkg::OP_MOVE, 16'sd110, 16'sd90, 4'd0);    // up-right diagonal
        send_event(gsdc_pkg::OP_MOVE, 16'sd120, 16'sd80, 4'd0);
        send_event(gsdc_pkg::OP_MOVE, 16'sd130, 16'sd90, 4'd0);    // down-right diagonal
        send_event(gsdc_pkg::OP_MOVE, 16'sd140, 16'sd100, 4'd0);
        send_event(gsdc_pkg::OP_MOVE, 16'sd130, 16'sd110, 4'd0);   // down-left diagonal
        send_event(gsdc_pkg::OP_MOVE, 16'sd120, 16'sd120, 4'd0);
        send_event(gsdc_pkg::OP_MOVE, 16'sd110, 16'sd110, 4'd0);   // up-left diagonal
        send_event(gsdc_pkg::OP_END, 16'sd100, 16'sd100, 4'd0);
    endtask

    // Fill the gesture, then show that further points, the end point among
    // them, are dropped, and that a restart empties it again.
    task automatic test_capacity_limit();
        int i;
        send_event(gsdc_pkg::OP_START, 16'sd0, 16'sd0, 4'd12);
        for (i = 1; i < gsdc_pkg::MAX_POINTS; i++)
            send_event(gsdc_pkg::OP_MOVE, CW'(20 * i), 16'sd0, 4'd0);
        for (i = 1; i <= 3; i++)
            send_event(gsdc_pkg::OP_MOVE, CW'(20 * (gsdc_pkg::MAX_POINTS - 1)),
                       CW'(20 * i), 4'd0);
        send_event(gsdc_pkg::OP_END, CW'(20 * (gsdc_pkg::MAX_POINTS - 1)), 16'sd80, 4'd0);
        send_event(gsdc_pkg::OP_START, 16'sd0, 16'sd0, 4'd6);
        send_event(gsdc_pkg::OP_MOVE, 16'sd0, 16'sd20, 4'd0);
        send_event(gsdc_pkg::OP_MOVE, 16'sd0, 16'sd40, 4'd0);
        send_event(gsdc_pkg::OP_END, 16'sd0, 16'sd60, 4'd0);
    endtask

    // One stroke: runs of similar steps so that directions repeat, mixed
    // with short steps, unused ops, restarts and stray requests after it.
    task automatic random_gesture();
        int                        i;
        int                        moves;
        int                        run;
        int                        reach;
        int                        sx;
        int                        sy;
        logic signed [CW-1:0]      cx;
        logic signed [CW-1:0]      cy;
        cx = CW'($urandom);
        cy = CW'($urandom);
        send_event(gsdc_pkg::OP_START, cx, cy, CDW'($urandom));
        moves = ($urandom_range(11) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 20);
        reach = 2 * int'(cfg_min_step) + $urandom_range(3, 40);
        run   = 0;
        sx    = 0;
        sy    = 0;
        for (i = 0; i < moves; i++) begin
            if (run == 0) begin
                run = $urandom_range(1, 5);
                sx  = signed_spread(reach);
                sy  = signed_spread(reach);
            end
            run--;
            case ($urandom_range(19))
                0: send_event(OP_UNUSED, CW'($urandom), CW'($urandom), CDW'($urandom));
                1: send_event(gsdc_pkg::OP_START, cx, cy, CDW'($urandom));
                2: begin
                    cx = CW'(int'(cx) + signed_spread(int'(cfg_min_step) / 2));
                    cy = CW'(int'(cy) + signed_spread(int'(cfg_min_step) / 2));
                    send_event(gsdc_pkg::OP_MOVE, cx, cy, CDW'($urandom));
                end
                default: begin
                    cx = CW'(int'(cx) + sx + signed_spread(1));
                    cy = CW'(int'(cy) + sy + signed_spread(1));
                    send_event(gsdc_pkg::OP_MOVE, cx, cy, CDW'($urandom));
                end
            endcase
        end
        // most strokes close; an open one is cut short by the next start
        if ($urandom_range(7) != 0) begin
            cx = CW'(int'(cx) + sx);
            cy = CW'(int'(cy) + sy);
            send_event(gsdc_pkg::OP_END, cx, cy, CDW'($urandom));
        end
        if ($urandom_range(3) == 0)
            send_event(($urandom_range(1) == 0) ? gsdc_pkg::OP_MOVE : gsdc_pkg::OP_END,
                       CW'($urandom), CW'($urandom), CDW'($urandom));
    endtask

    task automatic test_random_traffic(input t_idle_mode mode, input int margin,
                                       input int eight_way, input int target);
        int  first_taken;
        bit  paused;
        write_register(gsdc_pkg::CFG_MIN_STEP, margin);
        write_register(gsdc_pkg::CFG_EIGHT_WAY, eight_way);
        set_idling(mode);
        first_taken = requests_taken - requests_ignored;
        paused      = 1'b0;
        while (requests_taken - requests_ignored - first_taken < target) begin
            random_gesture();
            // hold off once mid-phase until every token has come back
            if (!paused && requests_taken - requests_ignored - first_taken >= target / 2) begin
                drain_tokens();
                paused = 1'b1;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_tokens();
        test_four_way_sectors();
        test_capacity_limit();
        test_random_traffic(IDLE_NONE, 16, 1, 75);
        test_random_traffic(IDLE_SENDER, 0, 0, 75);
        test_random_traffic(IDLE_RECEIVER, 1023, 1, 75);
        test_random_traffic(IDLE_BOTH, $urandom_range(1, 200), $urandom_range(1), 75);

        // stop stalling so that any stray token shows up before the verdict
        set_idling(IDLE_NONE);
        drain_tokens();

        $display("Ran %0d pointer requests (%0d of them ignored) and checked %0d tokens,",
                 requests_taken, requests_ignored, tokens_checked);
        $display("over margins 0 to 1023, both sector modes and four idling patterns.");
        if (token_mismatches == 0 && pending_tokens.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[sim.f]
design/gsdc_pkg.sv
design/gesture_stroke_direction_coder_top.sv
sim/gesture_stroke_direction_coder_top_tb.sv
